@@ design/twre_pkg.sv @@
// Shared types, constants and register codes for the timed register write encoder.
package twre_pkg;

    localparam int WAIT_BITS  = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 24;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [COUNT_W-1:0]   SIZE_CAP  = COUNT_W'(32256);
    localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [WAIT_BITS-1:0] PAD_STEP  = WAIT_BITS'(255);
    localparam logic [7:0]           END_PORT  = 8'hFF;
    localparam logic [7:0]           PAD_BYTE0 = 8'hFF;
    localparam logic [7:0]           PAD_BYTE1 = 8'hFE;
    localparam logic [7:0]           PAD_BYTE2 = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_DELTA_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHECKSUM = 2'd2;

    typedef struct packed {
        logic [WAIT_BITS-1:0] wait_ticks;
        logic [7:0]           port_number;
        logic [7:0]           write_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               last_byte;
        logic [7:0]         running_checksum;
        logic [COUNT_W-1:0] running_count;
    } out_item_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

    // classified request as it sits in the queue
    typedef struct packed {
        logic     mode;
        logic     is_end;
        logic     long_wait;
        in_item_t item;
    } q_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD0,
        ST_PAD1,
        ST_PAD2,
        ST_WAIT_LO,
        ST_WAIT_HI,
        ST_PORT,
        ST_VALUE
    } back_state_t;

endpackage

@@ design/twre_front.sv @@
// Front end: holds the mode register and classifies incoming requests.
module twre_front (
    input  logic                clk,
    input  logic                rst_n,
    input  twre_pkg::cfg_t      cfg,
    input  twre_pkg::in_item_t  in_item,
    output twre_pkg::q_entry_t  entry
);
    import twre_pkg::*;

    logic delta_mode_reg;
    logic delta_mode_next;

    always_comb
    begin
        delta_mode_next = delta_mode_reg;
        if (cfg.we && cfg.index == REG_DELTA_MODE)
        begin
            delta_mode_next = cfg.data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_mode_reg <= 1'b1;
        end
        else
        begin
            delta_mode_reg <= delta_mode_next;
        end
    end

    always_comb
    begin
        entry.mode      = delta_mode_reg;
        entry.is_end    = (in_item.port_number == END_PORT);
        entry.long_wait = (in_item.wait_ticks > PAD_STEP);
        entry.item      = in_item;
    end

endmodule

@@ design/twre_queue.sv @@
// Short request queue between front and back ends.
module twre_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  twre_pkg::q_entry_t  wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output twre_pkg::q_entry_t  rd_data,
    output logic                q_empty
);
    import twre_pkg::*;

    q_entry_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign q_full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/twre_back.sv @@
// Back end: byte sequencer, running count and checksum, output register.
module twre_back (
    input  logic                clk,
    input  logic                rst_n,
    input  twre_pkg::cfg_t      cfg,
    input  twre_pkg::q_entry_t  head,
    input  logic                q_empty,
    output logic                q_rd,
    output logic                out_valid,
    output twre_pkg::out_item_t out_item,
    input  logic                out_pop
);
    import twre_pkg::*;

    back_state_t          state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic                 mode_reg, mode_next;
    logic [WAIT_BITS-1:0] wait_reg, wait_next;
    logic [COUNT_W-1:0]   byte_total_reg, byte_total_next;
    logic [7:0]           xor_total_reg, xor_total_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 advance;
    logic                 drop;
    logic                 emit;
    logic                 emit_last;
    logic [7:0]           emit_byte;
    logic [WAIT_BITS-1:0] wait_less;

    assign advance   = !out_valid_reg || out_pop;
    assign drop      = head.mode && (byte_total_reg > SIZE_CAP) && !head.is_end;
    assign wait_less = wait_reg - PAD_STEP;
    assign q_rd      = (state_reg == ST_IDLE) && !q_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && !drop)
                begin
                    state_next = (head.mode && head.long_wait) ? ST_PAD0 : ST_WAIT_LO;
                end
            end
            ST_PAD0:    if (advance) state_next = ST_PAD1;
            ST_PAD1:    if (advance) state_next = ST_PAD2;
            ST_PAD2:    if (advance) state_next = (wait_less > PAD_STEP) ? ST_PAD0 : ST_WAIT_LO;
            ST_WAIT_LO: if (advance) state_next = mode_reg ? ST_PORT : ST_WAIT_HI;
            ST_WAIT_HI: if (advance) state_next = ST_PORT;
            ST_PORT:    if (advance) state_next = ST_VALUE;
            ST_VALUE:   if (advance) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // byte selection
    always_comb
    begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_byte = '0;
        case (state_reg)
            ST_IDLE:    emit = 1'b0;
            ST_PAD0:    begin emit = advance; emit_byte = PAD_BYTE0; end
            ST_PAD1:    begin emit = advance; emit_byte = PAD_BYTE1; end
            ST_PAD2:    begin emit = advance; emit_byte = PAD_BYTE2; end
            ST_WAIT_LO: begin emit = advance; emit_byte = wait_reg[7:0]; end
            ST_WAIT_HI: begin emit = advance; emit_byte = 8'(wait_reg >> 8); end
            ST_PORT:    begin emit = advance; emit_byte = item_reg.port_number; end
            ST_VALUE:
            begin
                emit      = advance;
                emit_byte = item_reg.write_value;
                emit_last = 1'b1;
            end
            default:    emit = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        item_next       = item_reg;
        mode_next       = mode_reg;
        wait_next       = wait_reg;
        byte_total_next = byte_total_reg;
        xor_total_next  = xor_total_reg;
        out_valid_next  = out_valid_reg && !out_pop;
        out_next        = out_reg;

        if (q_rd)
        begin
            item_next = head.item;
            mode_next = head.mode;
            wait_next = head.item.wait_ticks;
        end
        else if (emit && state_reg == ST_PAD2)
        begin
            wait_next = wait_less;
        end

        if (emit)
        begin
            xor_total_next  = xor_total_reg ^ emit_byte;
            byte_total_next = (byte_total_reg == COUNT_MAX) ? byte_total_reg
                                                            : byte_total_reg + 1'b1;
            out_valid_next            = 1'b1;
            out_next.out_byte         = emit_byte;
            out_next.last_byte        = emit_last;
            out_next.running_checksum = xor_total_next;
            out_next.running_count    = byte_total_next;
        end

        if (cfg.we && cfg.index == REG_START_COUNT)
        begin
            byte_total_next = COUNT_W'(cfg.data);
        end
        if (cfg.we && cfg.index == REG_START_CHECKSUM)
        begin
            xor_total_next = cfg.data[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_total_reg <= '0;
            xor_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_total_reg <= byte_total_next;
            xor_total_reg  <= xor_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mode_reg <= mode_next;
        wait_reg <= wait_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

@@ design/timed_register_write_encoder.sv @@
// Top level of the timed register write encoder: front, queue, back.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------
//  request   | push / full         | in_data  (wait_ticks, port_number, value)
//  result    | empty / pop         | out_data (byte, last, checksum, count)
//  config    | cfg_we              | cfg_index, cfg_data
//
// Each accepted request is classified at the input (mode, end marker, long
// wait) and parked in a two-entry queue. The back sequencer takes one request
// at a time: it loads the request while idle, then emits one byte per cycle
// (three or four, plus three per padding triple); a dropped request is read
// out in idle with no bytes. A full output register stalls the sequencer;
// the queue keeps accepting until it fills. Reset clears the queue, output
// register, mode (to one-byte wait) and both running totals.
module timed_register_write_encoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  twre_pkg::in_item_t                     in_data,
    output logic                                   empty,
    input  logic                                   pop,
    output twre_pkg::out_item_t                    out_data,
    input  logic                                   cfg_we,
    input  logic [twre_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [twre_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import twre_pkg::*;

    cfg_t      cfg;
    q_entry_t  front_entry;
    q_entry_t  head;
    logic      q_empty;
    logic      q_rd;
    logic      out_valid;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    twre_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_item (in_data),
        .entry   (front_entry)
    );

    // queue full doubles as the request-side full
    twre_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_entry),
        .q_full  (full),
        .rd_en   (q_rd),
        .rd_data (head),
        .q_empty (q_empty)
    );

    twre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .out_valid (out_valid),
        .out_item  (out_data),
        .out_pop   (pop)
    );

    assign empty = !out_valid;

endmodule

@@ design/twre_checker.sv @@
// Port-level checker for the timed register write encoder, with its bind.
module twre_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  logic                            pop,
    input  twre_pkg::out_item_t             out_data
);
    import twre_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("result changed while stalled");

    // within one request, count steps by one
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !out_data.last_byte && out_data.running_count != COUNT_MAX)
        ##1 !empty |-> out_data.running_count == $past(out_data.running_count) + 1'b1)
        else $error("running count did not step");

    // within one request, checksum folds in each byte
    a_xor: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !out_data.last_byte) ##1 !empty
        |-> out_data.running_checksum ==
            ($past(out_data.running_checksum) ^ out_data.out_byte))
        else $error("running checksum mismatch");

    // nothing pending right after reset
    a_reset: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result present after reset");

endmodule

bind timed_register_write_encoder twre_checker u_twre_checker (.*);

@@ test/timed_register_write_encoder_tb.sv @@
// Self-checking testbench for the timed register write encoder: directed table, then random phases.
module timed_register_write_encoder_tb;
    import twre_pkg::*;

    localparam int ITEMS       = 280;        // random requests offered, dropped ones included
    localparam int LIMIT       = 1_000_000;  // watchdog, in clock cycles
    localparam int SETTLE      = 12;         // lets dropped requests still in flight fall through
    localparam int TAIL        = 24;         // quiet cycles after the last byte
    localparam int HOLD_CYCLES = 400;        // long receiver hold-off
    localparam int NO_CHECK    = -1;

    // index 3 decodes to nothing; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic { ROW_REQ, ROW_CFG } row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        in_item_t              req;
        int                    n_exp;      // byte count read off by hand, or NO_CHECK
        logic [7:0]            first_exp;  // first byte read off by hand
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    in_item_t              in_data   = '0;
    logic                  full;
    logic                  empty;
    logic                  pop       = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // encoder mirror: mode plus running totals, starting at their reset values
    logic               enc_mode  = 1'b1;
    logic [COUNT_W-1:0] enc_count = '0;
    logic [7:0]         enc_xor   = '0;

    out_item_t   expected_bytes[$];   // predicted stream, oldest first
    plan_row_t   plan[$];
    int          mismatches    = 0;
    bit          hold_request  = 1'b0;   // stimulus asks the sink for a long hold-off
    int unsigned cycles        = 0;

    timed_register_write_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_data   (in_data),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // one emitted byte: fold into checksum, bump the saturating count
    function automatic void put_byte(input logic [7:0] b, input logic last);
        out_item_t o;
        enc_xor = enc_xor ^ b;
        if (enc_count != COUNT_MAX)
            enc_count = enc_count + 1'b1;
        o.out_byte         = b;
        o.last_byte        = last;
        o.running_checksum = enc_xor;
        o.running_count    = enc_count;
        expected_bytes.push_back(o);
    endfunction

    // expand one request into its byte stream; returns the byte count
    function automatic int encode_write(input in_item_t it, output logic [7:0] first_byte);
        logic [WAIT_BITS-1:0] w;
        int                   base;
        w          = it.wait_ticks;
        base       = expected_bytes.size();
        first_byte = '0;
        if (enc_mode == 1'b0)
        begin
            put_byte(w[7:0], 1'b0);
            put_byte(8'(w >> 8), 1'b0);
        end
        else
        begin
            // past the size cap only the end marker gets through
            if (enc_count > SIZE_CAP && it.port_number != END_PORT)
                return 0;
            while (w > PAD_STEP)
            begin
                put_byte(PAD_BYTE0, 1'b0);
                put_byte(PAD_BYTE1, 1'b0);
                put_byte(PAD_BYTE2, 1'b0);
                w = w - PAD_STEP;
            end
            put_byte(w[7:0], 1'b0);
        end
        put_byte(it.port_number, 1'b0);
        put_byte(it.write_value, 1'b1);
        first_byte = expected_bytes[base].out_byte;
        return expected_bytes.size() - base;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DELTA_MODE:     enc_mode  = data[0];
            REG_START_COUNT:    enc_count = COUNT_W'(data);
            REG_START_CHECKSUM: enc_xor   = data[7:0];
            default:            ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers; all called right after a rising edge
    // ------------------------------------------------------------------

    function automatic void add_req(input logic [WAIT_BITS-1:0] wt, input logic [7:0] port,
                                    input logic [7:0] value, input int n_exp = NO_CHECK,
                                    input logic [7:0] first_exp = '0);
        plan_row_t r;
        r.kind      = ROW_REQ;
        r.reg_idx   = '0;
        r.reg_data  = '0;
        r.req       = '{wt, port, value};
        r.n_exp     = n_exp;
        r.first_exp = first_exp;
        plan.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r.kind      = ROW_CFG;
        r.reg_idx   = idx;
        r.reg_data  = data;
        r.req       = '0;
        r.n_exp     = NO_CHECK;
        r.first_exp = '0;
        plan.push_back(r);
    endfunction

    // offer a request and hold it until accepted; push is left high so a
    // back-to-back request never lowers and raises it in one step
    task automatic send_request(input in_item_t it, output int n, output logic [7:0] first);
        push    <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (full);
        n = encode_write(it, first);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop offering, wait for every predicted byte, then let dropped
    // requests still in the queue fall through
    task automatic drain();
        push <= 1'b0;
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic in_item_t random_request();
        in_item_t it;
        case ($urandom_range(0, 15))
            0:       it.wait_ticks = $urandom_range(0, 1) ? '1 : '0;
            1, 2:    it.wait_ticks = WAIT_BITS'($urandom_range(256, 1100));
            3:       it.wait_ticks = WAIT_BITS'($urandom_range(0, (1 << WAIT_BITS) - 1));
            4:       it.wait_ticks = WAIT_BITS'($urandom_range(254, 257));
            default: it.wait_ticks = WAIT_BITS'($urandom_range(0, 255));
        endcase
        // end markers now and then so capped phases still move
        it.port_number = ($urandom_range(0, 11) == 0) ? END_PORT : 8'($urandom_range(0, 255));
        it.write_value = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Result sink: checks every popped byte, stalls on its own pattern
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int        pat;
        int        pat_left;
        int        hold_left;
        bit        flip;
        out_item_t want;
        pat       = 0;
        pat_left  = 0;
        hold_left = 0;
        flip      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                    flag_mismatch("unexpected byte", out_data.out_byte, 0);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.last_byte !== want.last_byte)
                        flag_mismatch("last_byte", out_data.last_byte, want.last_byte);
                    if (out_data.running_checksum !== want.running_checksum)
                        flag_mismatch("running_checksum", out_data.running_checksum,
                                      want.running_checksum);
                    if (out_data.running_count !== want.running_count)
                        flag_mismatch("running_count", out_data.running_count,
                                      want.running_count);
                end
            end

            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                // long hold-off: the encoder backs up and raises full
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat      = $urandom_range(0, 3);
                    pat_left = $urandom_range(16, 128);
                end
                pat_left--;
                flip = !flip;
                case (pat)
                    0:       pop <= 1'b1;                        // always ready
                    1:       pop <= flip;                        // alternating
                    2:       pop <= 1'($urandom_range(0, 1));    // coin toss
                    default: pop <= ($urandom_range(0, 4) == 0); // mostly stalled
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                    n;
        logic [7:0]            first;
        int                    produced;
        int                    phase;
        int                    phase_len;
        int                    burst_left;
        bit                    no_gaps;
        logic [CFG_DATA_W-1:0] data;

        produced = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Right after reset: one-byte wait, count 0, checksum 0.
        add_req(12'd0,    8'h00, 8'h00, 3,  8'h00);   // all-zero request
        add_req(12'd255,  8'hFF, 8'hFF, 3,  8'hFF);   // largest wait without padding
        add_req(12'd256,  8'h12, 8'h34, 6,  8'hFF);   // first wait that needs a pad triple
        add_req(12'hFFF,  8'h00, 8'hFF, 51, 8'hFF);   // longest wait: sixteen pad triples
        add_req(12'd510,  8'h7F, 8'h80, 6,  8'hFF);   // pads leave exactly 255
        add_req(12'hAAA,  8'h55, 8'hAA);
        add_cfg(REG_UNUSED, 16'hFFFE);                 // unknown index: mode must stay 1
        add_req(12'h555,  8'hAA, 8'h55);
        add_cfg(REG_DELTA_MODE, 16'h0000);             // two-byte wait
        add_req(12'hFFF,  8'h00, 8'h00, 4,  8'hFF);
        add_req(12'h100,  8'h01, 8'h02, 4,  8'h00);
        add_req(12'h555,  8'hAA, 8'h55);
        add_cfg(REG_DELTA_MODE, 16'h0001);
        add_cfg(REG_START_COUNT, 16'd32255);           // just under the size cap
        add_cfg(REG_START_CHECKSUM, 16'h00A5);
        add_req(12'd0,    8'h01, 8'h02, 3,  8'h00);   // goes out, count passes the cap
        add_req(12'd5,    8'h03, 8'h04, 0);            // dropped
        add_req(12'hFFF,  8'h10, 8'h20, 0);            // dropped, long wait too
        add_req(12'd300,  8'hFF, 8'h00, 6,  8'hFF);   // end marker still passes
        add_req(12'd0,    8'hFE, 8'h01, 0);            // port one below the end marker
        add_cfg(REG_START_COUNT, 16'd32256);           // exactly at the cap: not over it
        add_req(12'd1,    8'h02, 8'h03, 3,  8'h01);
        add_req(12'd1,    8'h02, 8'h03, 0);            // now over
        add_cfg(REG_DELTA_MODE, 16'h0000);             // no cap in two-byte mode
        add_cfg(REG_START_COUNT, 16'hFFFF);            // count runs past 16 bits
        add_cfg(REG_START_CHECKSUM, 16'hFFFF);
        add_req(12'h123,  8'h80, 8'h01, 4,  8'h23);
        add_req(12'h0FF,  8'hFF, 8'hFF, 4,  8'hFF);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end
            else
            begin
                send_request(plan[i].req, n, first);
                if (plan[i].n_exp != NO_CHECK)
                begin
                    if (n != plan[i].n_exp)
                        flag_mismatch($sformatf("row %0d byte count", i), n, plan[i].n_exp);
                    else if (n > 0 && first !== plan[i].first_exp)
                        flag_mismatch($sformatf("row %0d first byte", i), first,
                                      plan[i].first_exp);
                end
            end
        end

        // Random phases: fresh settings at each idle boundary.
        phase      = 0;
        burst_left = 0;
        while (produced < ITEMS)
        begin
            drain();

            data    = 16'($urandom);
            data[0] = (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            write_reg(REG_DELTA_MODE, data);
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = 16'(SIZE_CAP);
                    3:       data = 16'(SIZE_CAP) - 16'($urandom_range(0, 60));
                    4:       data = 16'($urandom);
                    default: data = 16'($urandom_range(0, 2000));
                endcase
                write_reg(REG_START_COUNT, data);
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_START_CHECKSUM, 16'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, 16'($urandom));

            // second phase: two-byte mode, sink holds off, requests keep coming
            no_gaps = (phase == 1) || ($urandom_range(0, 4) == 0);
            if (phase == 1)
                hold_request = 1'b1;

            phase_len = $urandom_range(20, 50);
            for (int k = 0; k < phase_len && produced < ITEMS; k++)
            begin
                if (!no_gaps && burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                end
                if (burst_left > 0)
                    burst_left--;
                send_request(random_request(), n, first);
                produced++;
                // now and then wait for the stream to run dry mid-phase
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            phase++;
        end

        push <= 1'b0;
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
